// ----- sv/sflg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and LFO table functions for the stereo flanger.
// No dependencies; sflg_mul, stereo_flanger and the testbench import this package.
package sflg_pkg;

  // Defaults for the top level parameters
  localparam int FRAMES_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int SINE_ENTRIES_DEF = 256;

  // Register and field widths
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DELAY_W   = 10;
  localparam int STEP_W    = 16;
  localparam int GAIN_W    = 15;
  localparam int PHASE_W   = 16;
  localparam int LFO_W     = 16;

  // Second operand width of the shared multiplier
  localparam int MB_W = 17;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN  = 3'd4;

  // Unity gain in Q1.14
  localparam logic [GAIN_W-1:0] GAIN_ONE = 15'd16384;

  // Mix coefficients in Q16: one third and one tenth
  localparam logic signed [MB_W-1:0] THIRD_Q16 = 17'sd21845;
  localparam logic signed [MB_W-1:0] TENTH_Q16 = 17'sd6554;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_SWING,
    S_DELAY,
    S_ADDR,
    S_READ,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_DONE
  } state_t;

  // Operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_PHASE,
    MUL_SWING,
    MUL_XSUM,
    MUL_FB,
    MUL_DRY,
    MUL_WET
  } mul_op_t;

  // sin(pi/2 * t), t and result in Q15, clamped to 1.0
  function automatic longint unsigned sine_q15(longint unsigned t);
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned outer;
    longint unsigned s;
    t2    = (t * t) >> 15;
    inner = 64'd21167 - ((t2 * 64'd2611) >> 15);
    outer = 64'd51472 - ((t2 * inner) >> 15);
    s     = (t * outer) >> 15;
    return (s > 64'd32768) ? 64'd32768 : s;
  endfunction

  // Raised sine 0.5*(1+sin) in Q15 at a 16-bit phase p
  function automatic logic [LFO_W-1:0] lfo_entry(longint unsigned p);
    longint unsigned quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned s;
    longint unsigned h;
    quad = (p >> 14) & 64'd3;
    r    = (p & 64'h3FFF) * 64'd2;
    t    = quad[0] ? (64'd32768 - r) : r;
    s    = sine_q15(t);
    h    = (quad < 64'd2) ? ((64'd32768 + s) >> 1) : ((64'd32768 - s) >> 1);
    return h[LFO_W-1:0];
  endfunction

endpackage

// ----- sv/sflg_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and output stereo frames.
// Depends on nothing; sized by SAMPLE_BITS.
interface sflg_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sflg_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ----- sv/sflg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sflg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/sflg_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with operand selection and a registered product.
// Depends on sflg_pkg.
module sflg_mul import sflg_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
  localparam int MA_W        = SAMPLE_BITS + 18,
  localparam int PW          = MA_W + MB_W
) (
  input  logic                          clk,
  input  mul_op_t                       op,
  input  logic [PHASE_W-1:0]            phase,
  input  logic [DELAY_W-1:0]            swing,
  input  logic [LFO_W-1:0]              h,
  input  logic signed [SAMPLE_BITS:0]   xsum,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] yd,
  input  logic signed [MA_W-1:0]        ws,
  input  logic [GAIN_W-1:0]             wet,
  input  logic [GAIN_W-1:0]             dry,
  output logic signed [PW-1:0]          prod
);

  logic signed [MA_W-1:0] a;
  logic signed [MB_W-1:0] b;

  // Pick the operand pair
  always_comb begin
    unique case (op)
      MUL_PHASE: begin
        a = MA_W'(phase);
        b = MB_W'(SINE_ENTRIES);
      end
      MUL_SWING: begin
        a = MA_W'(swing);
        b = MB_W'(h);
      end
      MUL_XSUM: begin
        a = MA_W'(xsum);
        b = THIRD_Q16;
      end
      MUL_FB: begin
        a = MA_W'(yd);
        b = TENTH_Q16;
      end
      MUL_DRY: begin
        a = MA_W'(x);
        b = MB_W'(dry);
      end
      MUL_WET: begin
        a = ws;
        b = MB_W'(wet);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- sv/stereo_flanger.sv -----
`timescale 1ns / 1ps
// Stereo flanger top level: LFO-swept delay with feedback, one frame at a time.
// Depends on sflg_pkg, sflg_if, sflg_ram and sflg_mul.
//
// Channel     Dir   Payload                      Transfer
// frame_in    in    left_in, right_in            valid and ready high
// frame_out   out   left_out, right_out          valid and ready high
// cfg         in    cfg_we, cfg_idx, cfg_data    cfg_we high
//
// The one shared multiplier orders the work from a frame's transfer to the result
// in the output register, and no new frame is taken before that work ends: five
// steps for the delay and the ring read, then six per channel for the mix.
// After reset a clearing pass zeroes every slot of both rings; frame_in is
// not ready meanwhile. Configuration writes are taken at any time.
// A result not yet taken holds the block in its last step; a new frame is
// taken while the previous result still waits in the output register.
module stereo_flanger import sflg_pkg::*; #(
  parameter int FRAMES       = FRAMES_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  sflg_in_if.sink               frame_in,
  sflg_out_if.source            frame_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(FRAMES);
  localparam int DW   = (AW > 12) ? AW : 12;
  localparam int IW   = $clog2(SINE_ENTRIES);
  localparam int MA_W = SB + 18;
  localparam int PW   = MA_W + MB_W;
  localparam int YW   = PW - 30;

  localparam logic signed [PW-1:0] ROUND = PW'(1) <<< 29;
  localparam logic signed [YW-1:0] Y_MAX = YW'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

  // Configuration registers
  logic [DELAY_W-1:0] min_delay;
  logic [DELAY_W-1:0] max_delay;
  logic [STEP_W-1:0]  lfo_step;
  logic [GAIN_W-1:0]  wet_gain;
  logic [GAIN_W-1:0]  dry_gain;

  // Control state
  state_t             state;
  state_t             state_next;
  logic [PHASE_W-1:0] lfo_phase;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      clr_cnt;
  logic               ch;
  logic               out_valid;

  // Payload registers
  logic signed [SB-1:0]   x_l;
  logic signed [SB-1:0]   x_r;
  logic signed [SB-1:0]   y_l;
  logic signed [SB-1:0]   y_r;
  logic signed [SB-1:0]   out_l;
  logic signed [SB-1:0]   out_r;
  logic [LFO_W-1:0]       h;
  logic [AW-1:0]          d;
  logic                   zero_dly;
  logic [AW-1:0]          rd_addr;
  logic signed [MA_W-1:0] ws;
  logic signed [PW-1:0]   acc;

  // Sequencer outputs
  mul_op_t             mul_op;
  logic                ram_we;
  logic                accept;
  logic                go;

  // Datapath wires
  logic signed [PW-1:0] prod;
  logic [LFO_W-1:0]     lfo_rom [SINE_ENTRIES];
  logic [IW:0]          idx_w;
  logic [IW-1:0]        idx;
  logic [DELAY_W-1:0]   swing;
  logic [26:0]          off_sum;
  logic [DW-1:0]        d_raw;
  logic [AW-1:0]        d_clamp;
  logic [AW:0]          diff;
  logic [AW:0]          wrap;
  logic [AW-1:0]        rd;
  logic [AW-1:0]        wp_inc;
  logic [AW-1:0]        wr_addr;
  logic [2*SB-1:0]      in_wr;
  logic [2*SB-1:0]      out_wr;
  logic [2*SB-1:0]      in_rd;
  logic [2*SB-1:0]      out_rd;
  logic signed [SB-1:0] x_cur;
  logic signed [SB-1:0] xd;
  logic signed [SB-1:0] yd;
  logic signed [SB:0]   xsum;
  logic signed [YW-1:0] yv;
  logic signed [SB-1:0] y_sat;

  // Raised-sine table, built at elaboration
  for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
    localparam longint unsigned P = (longint'(i) * 65536) / SINE_ENTRIES;
    assign lfo_rom[i] = lfo_entry(P);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay <= '0;
      max_delay <= '0;
      lfo_step  <= '0;
      wet_gain  <= GAIN_ONE;
      dry_gain  <= GAIN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_DELAY: min_delay <= cfg_data[DELAY_W-1:0];
        CFG_MAX_DELAY: max_delay <= cfg_data[DELAY_W-1:0];
        CFG_LFO_STEP:  lfo_step  <= cfg_data[STEP_W-1:0];
        CFG_WET_GAIN:  wet_gain  <= cfg_data[GAIN_W-1:0];
        CFG_DRY_GAIN:  dry_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // LFO index, delay and read slot
  assign idx_w   = prod[IW+16:16];
  assign idx     = (idx_w >= (IW+1)'(SINE_ENTRIES)) ? IW'(SINE_ENTRIES - 1) : idx_w[IW-1:0];
  assign swing   = (max_delay > min_delay) ? (max_delay - min_delay) : '0;
  assign off_sum = prod[26:0] + 27'd16384;
  assign d_raw   = DW'(min_delay) + DW'(off_sum[26:15]);
  assign d_clamp = (d_raw > DW'(FRAMES - 1)) ? AW'(FRAMES - 1) : d_raw[AW-1:0];
  assign diff    = {1'b0, wp} - {1'b0, d};
  assign wrap    = diff + (AW+1)'(FRAMES);
  assign rd      = diff[AW] ? wrap[AW-1:0] : diff[AW-1:0];
  assign wp_inc  = (wp == AW'(FRAMES - 1)) ? '0 : wp + AW'(1);

  // Channel operands; a zero delay reads the current input
  assign x_cur = ch ? x_r : x_l;
  assign xd    = zero_dly ? x_cur : (ch ? in_rd[2*SB-1:SB] : in_rd[SB-1:0]);
  assign yd    = ch ? out_rd[2*SB-1:SB] : out_rd[SB-1:0];
  assign xsum  = (SB+1)'(x_cur) + (SB+1)'(xd);

  // Round already added; take the integer part and saturate
  assign yv    = acc[PW-1:30];
  assign y_sat = (yv > Y_MAX) ? SB'(Y_MAX) : ((yv < Y_MIN) ? SB'(Y_MIN) : yv[SB-1:0]);

  // Ring writes: zero during clearing, else this frame at the write slot
  assign wr_addr = (state == S_CLEAR) ? clr_cnt : wp;
  assign in_wr   = (state == S_CLEAR) ? '0 : {x_r, x_l};
  assign out_wr  = (state == S_CLEAR) ? '0 : {y_r, y_l};

  assign go     = !out_valid || frame_out.ready;
  assign accept = frame_in.valid && frame_in.ready;

  // Next state and sequencer outputs
  always_comb begin
    state_next     = state;
    mul_op         = MUL_PHASE;
    ram_we         = 1'b0;
    frame_in.ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == AW'(FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        frame_in.ready = 1'b1;
        mul_op         = MUL_PHASE;
        if (frame_in.valid) begin
          state_next = S_INDEX;
        end
      end
      S_INDEX: state_next = S_SWING;
      S_SWING: begin
        mul_op     = MUL_SWING;
        state_next = S_DELAY;
      end
      S_DELAY: state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_M1;
      S_M1: begin
        mul_op     = MUL_XSUM;
        state_next = S_M2;
      end
      S_M2: begin
        mul_op     = MUL_FB;
        state_next = S_M3;
      end
      S_M3: begin
        mul_op     = MUL_DRY;
        state_next = S_M4;
      end
      S_M4: begin
        mul_op     = MUL_WET;
        state_next = S_M5;
      end
      S_M5: state_next = S_M6;
      S_M6: state_next = ch ? S_DONE : S_M1;
      S_DONE: begin
        if (go) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      wp        <= '0;
      lfo_phase <= '0;
      ch        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      // Advance the write slot and the phase once per frame
      if (accept) begin
        wp        <= wp_inc;
        lfo_phase <= lfo_phase + lfo_step;
        ch        <= 1'b0;
      end
      if (state == S_M6) begin
        ch <= 1'b1;
      end
      // Hold the result until its transfer
      if (state == S_DONE && go) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_l <= frame_in.left_in;
      x_r <= frame_in.right_in;
    end
    case (state)
      S_INDEX: h        <= lfo_rom[idx];
      S_DELAY: d        <= d_clamp;
      S_ADDR: begin
        rd_addr  <= rd;
        zero_dly <= (d == '0);
      end
      S_M2:    ws       <= prod[MA_W-1:0];
      S_M3:    ws       <= ws + prod[MA_W-1:0];
      S_M4:    acc      <= prod <<< 16;
      S_M5:    acc      <= acc + prod + ROUND;
      S_M6: begin
        if (ch) begin
          y_r <= y_sat;
        end else begin
          y_l <= y_sat;
        end
      end
      S_DONE: begin
        if (go) begin
          out_l <= y_l;
          out_r <= y_r;
        end
      end
      default: ;
    endcase
  end

  assign frame_out.valid     = out_valid;
  assign frame_out.left_out  = out_l;
  assign frame_out.right_out = out_r;

  // Input ring, both channels side by side
  sflg_ram #(
    .WIDTH (2 * SB),
    .DEPTH (FRAMES)
  ) u_in_ring (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (in_wr),
    .rd_addr (rd_addr),
    .rd_data (in_rd)
  );

  // Output ring for the feedback path
  sflg_ram #(
    .WIDTH (2 * SB),
    .DEPTH (FRAMES)
  ) u_out_ring (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (out_wr),
    .rd_addr (rd_addr),
    .rd_data (out_rd)
  );

  // Shared multiplier
  sflg_mul #(
    .SAMPLE_BITS  (SB),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_mul (
    .clk   (clk),
    .op    (mul_op),
    .phase (lfo_phase),
    .swing (swing),
    .h     (h),
    .xsum  (xsum),
    .x     (x_cur),
    .yd    (yd),
    .ws    (ws),
    .wet   (wet_gain),
    .dry   (dry_gain),
    .prod  (prod)
  );

endmodule

// ----- sv/sflg_check.sv -----
`timescale 1ns / 1ps
// Port-level checker for the stereo flanger, bound to the top level.
// Depends on stereo_flanger for the bind target.
module sflg_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result waiting for its transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // The clearing pass follows reset, so no frame is taken right after it
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("frame input ready right after reset");

  // A frame transfer makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("frame input ready while a frame is in work");

  // A new result only comes out of a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

endmodule

bind stereo_flanger sflg_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame_in.valid),
  .in_ready  (frame_in.ready),
  .out_valid (frame_out.valid),
  .out_ready (frame_out.ready)
);

// ----- tb/tb_stereo_flanger.sv -----
`timescale 1ns / 1ps
// Testbench for stereo_flanger: directed and random stereo frames under random
// source gaps and sink stalls, each result checked against an in-bench flanger model.
// Depends on sflg_pkg, sflg_if and the stereo_flanger RTL.
module tb_stereo_flanger import sflg_pkg::*; ();

  localparam int RING          = 1024;
  localparam int LUT_SIZE      = 256;
  localparam int PHASE_FRAMES  = 204;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;
  localparam longint THIRD_Q16 = 21845;
  localparam longint TENTH_Q16 = 6554;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sflg_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  sflg_out_if #(.SAMPLE_BITS(16)) out_ch ();

  stereo_flanger u_top (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (in_ch),
    .frame_out (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  // Register shadows
  logic [9:0]  min_dly;
  logic [9:0]  max_dly;
  logic [15:0] lfo_inc;
  logic [14:0] wet_q14;
  logic [14:0] dry_q14;

  // Flanger state: LFO, ring head and the four rings
  logic [15:0]        sweep_lut [LUT_SIZE];
  logic [15:0]        lfo_acc;
  logic [9:0]         head;
  logic signed [15:0] x_hist_l [RING];
  logic signed [15:0] x_hist_r [RING];
  logic signed [15:0] y_hist_l [RING];
  logic signed [15:0] y_hist_r [RING];

  frame_t pending_frames [$];
  frame_t expected_frames [$];

  int send_idle;
  int recv_idle;
  int hold_at;
  int hold_cnt;
  int accepted_cnt;
  int fail_count;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Wet and dry mix of one sample, rounded half up and saturated
  function automatic logic signed [15:0] mix_sample(longint x, longint xd, longint yd);
    longint wet_sum;
    longint acc;
    longint y;
    wet_sum = (x + xd) * THIRD_Q16 + yd * TENTH_Q16;
    acc = wet_sum * longint'(wet_q14) + x * longint'(dry_q14) * 65536;
    y = (acc + 64'sd536870912) >>> 30;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[15:0];
  endfunction

  // Advance the flanger by one frame and return the processed frame
  function automatic frame_t flange_frame(frame_t x);
    int unsigned swing;
    int unsigned h;
    int unsigned d;
    logic [9:0]  rd;
    frame_t      y;
    h = 32'(sweep_lut[lfo_acc[15:8]]);
    swing = (max_dly > min_dly) ? 32'(max_dly - min_dly) : 0;
    d = 32'(min_dly) + ((swing * h + 16384) >> 15);
    if (d > RING - 1) d = RING - 1;
    head = head + 1'b1;
    x_hist_l[head] = x.left;
    x_hist_r[head] = x.right;
    rd = head - d[9:0];
    y.left  = mix_sample(x.left, x_hist_l[rd], y_hist_l[rd]);
    y.right = mix_sample(x.right, x_hist_r[rd], y_hist_r[rd]);
    y_hist_l[head] = y.left;
    y_hist_r[head] = y.right;
    lfo_acc = lfo_acc + lfo_inc;
    return y;
  endfunction

  // Half full-range noise, some quiet passages, some rail, zero and all-ones values
  function automatic logic [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return 16'($urandom);
    if (pick < 8) return 16'($urandom_range(4095) - 2048);
    case ($urandom_range(3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // One register write, mirrored into the shadows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_DELAY: min_dly = val[9:0];
      CFG_MAX_DELAY: max_dly = val[9:0];
      CFG_LFO_STEP:  lfo_inc = val[15:0];
      CFG_WET_GAIN:  wet_q14 = val[14:0];
      CFG_DRY_GAIN:  dry_q14 = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] step, input logic [15:0] wet,
                            input logic [15:0] dry);
    write_reg(CFG_MIN_DELAY, lo);
    write_reg(CFG_MAX_DELAY, hi);
    write_reg(CFG_LFO_STEP, step);
    write_reg(CFG_WET_GAIN, wet);
    write_reg(CFG_DRY_GAIN, dry);
  endtask

  task automatic offer(input logic [15:0] l, input logic [15:0] r);
    frame_t f;
    f.left  = l;
    f.right = r;
    pending_frames.push_back(f);
  endtask

  task automatic queue_frames(input int n);
    @(negedge clk);
    repeat (n) offer(rand_sample(), rand_sample());
  endtask

  // Block until every queued frame went in and every result came out
  task automatic wait_idle();
    @(negedge clk);
    while (pending_frames.size() != 0 || in_ch.valid || expected_frames.size() != 0)
      @(negedge clk);
  endtask

  // Source side: offer queued frames, predict on each transfer
  always @(posedge clk) begin : drive_frames
    frame_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        nxt.left  = in_ch.left_in;
        nxt.right = in_ch.right_in;
        expected_frames.push_back(flange_frame(nxt));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = pending_frames.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= nxt.left;
        in_ch.right_in <= nxt.right;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long sink hold-off, started by a chosen input transfer
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (in_ch.valid && in_ch.ready && accepted_cnt == hold_at) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Sink side: check each transfer against the oldest expectation
  always @(posedge clk) begin : check_frames
    frame_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected frame L=%0d R=%0d", out_ch.left_out, out_ch.right_out);
        end else begin
          want = expected_frames.pop_front();
          if (out_ch.left_out !== want.left || out_ch.right_out !== want.right) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                       want.left, want.right, out_ch.left_out, out_ch.right_out);
          end
        end
      end
      out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Stimulus and phase sequencing
  initial begin : stimulus
    longint unsigned p;
    longint unsigned r;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned inner;
    longint unsigned outer;
    longint unsigned s;
    int unsigned     quad;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    out_ch.ready   = 1'b0;
    send_idle      = 29;
    recv_idle      = 82;
    hold_at        = -1;
    accepted_cnt   = 0;
    fail_count     = 0;

    // Model reset state
    min_dly = '0;
    max_dly = '0;
    lfo_inc = '0;
    wet_q14 = GAIN_ONE;
    dry_q14 = GAIN_ONE;
    lfo_acc = '0;
    head    = '0;
    for (int i = 0; i < RING; i++) begin
      x_hist_l[i] = '0;
      x_hist_r[i] = '0;
      y_hist_l[i] = '0;
      y_hist_r[i] = '0;
    end

    // Raised-sine sweep table from a quarter-wave polynomial
    for (int i = 0; i < LUT_SIZE; i++) begin
      p     = (longint'(i) * 65536) / LUT_SIZE;
      quad  = 32'((p >> 14) & 3);
      r     = (p & 16'h3FFF) * 2;
      t     = quad[0] ? 32768 - r : r;
      t2    = (t * t) >> 15;
      inner = 21167 - ((t2 * 2611) >> 15);
      outer = 51472 - ((t2 * inner) >> 15);
      s     = (t * outer) >> 15;
      if (s > 32768) s = 32768;
      sweep_lut[i] = 16'((quad < 2) ? (32768 + s) >> 1 : (32768 - s) >> 1);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero delay, unity gains, rails and sign patterns
    @(negedge clk);
    offer(16'h0000, 16'h0000);
    offer(16'h7FFF, 16'h8000);
    offer(16'h8000, 16'h7FFF);
    offer(16'hFFFF, 16'h0001);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h8000, 16'h8000);
    offer(16'h5555, 16'hAAAA);
    wait_idle();

    // Max below min, full gains, high bits dropped, unmapped indexes ignored
    set_config(16'hFC03, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int k = int'(CFG_DRY_GAIN) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 16'hFFFF);
    @(negedge clk);
    offer(16'h7FFF, 16'h8000);
    offer(16'h7FFF, 16'h8000);
    offer(16'h8000, 16'h7FFF);
    offer(16'h8000, 16'h7FFF);
    offer(16'h4000, 16'hC000);
    offer(16'h0001, 16'hFFFF);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h8000, 16'h8000);
    wait_idle();

    // Full sweep in quarter turns: trough, middle, peak
    set_config(16'd0, 16'd1023, 16'd16384, 16'd16384, 16'd0);
    @(negedge clk);
    offer(16'h7FFF, 16'h8000);
    offer(16'h1234, 16'hEDCB);
    offer(16'h8000, 16'h7FFF);
    offer(16'h0F0F, 16'hF0F0);
    offer(16'h7FFF, 16'h7FFF);
    offer(16'h8000, 16'h8000);
    offer(16'h00FF, 16'hFF00);
    offer(16'h3333, 16'hCCCC);
    wait_idle();

    // Random phases under three idling modes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle = 29;
        recv_idle = 82;
      end else if (ph < 6) begin
        send_idle = 82;
        recv_idle = 29;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: set_config(16'd0, 16'd1023, 16'hFFFF, 16'd32767, 16'd0);
        1: set_config(16'd5, 16'd40, 16'd300, 16'd16384, 16'd16384);
        2: set_config(16'd1023, 16'd1023, 16'd0, 16'd8000, 16'd20000);
        3: set_config(16'd200, 16'd100, 16'd1234, 16'd0, 16'd32767);
        4: set_config(16'($urandom_range(63)), 16'($urandom_range(63)), 16'($urandom),
                      16'($urandom_range(32767)), 16'($urandom_range(32767)));
        5: set_config(16'd0, 16'd0, 16'($urandom), 16'd32767, 16'd32767);
        6: set_config(16'($urandom_range(1023)), 16'($urandom_range(1023)), 16'($urandom),
                      16'($urandom_range(32767)), 16'($urandom_range(32767)));
        default: set_config(16'd1, 16'd8, 16'($urandom_range(2000)), 16'd24000, 16'd9000);
      endcase
      @(negedge clk);
      // Stall the sink mid-phase while the source keeps offering
      if (ph == 6) hold_at = accepted_cnt + 60;
      queue_frames(PHASE_FRAMES);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
